// ===== rtl/apc_pkg.sv =====
`timescale 1ns / 1ps

package apc_pkg;

	typedef enum logic [1:0] {
		OP_SAMPLE = 2'd0,
		OP_UP     = 2'd1,
		OP_DOWN   = 2'd2,
		OP_TOGGLE = 2'd3
	} opcode_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;
	localparam int GAIN_W     = 24;
	localparam int COUNT_W    = 10;
	localparam int SP_W       = 7;
	localparam int VAL_W      = 15;
	localparam int ERR_W      = 16;
	localparam int SUM_W      = 32;
	localparam int MUL_A_W    = 33;
	localparam int MUL_B_W    = 25;
	localparam int ACC_W      = MUL_A_W + MUL_B_W;
	localparam int QBITS      = 15;
	localparam int DIV_CNT_W  = 4;
	localparam int OUT_TDATA_W = 40;

	localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG_DT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV_DT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPAN_COUNTS    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CLIP_MARGIN    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_START_SETPOINT = 3'd5;

	localparam logic [GAIN_W-1:0]  RST_GAIN_PROP      = 24'd196608;
	localparam logic [GAIN_W-1:0]  RST_GAIN_INTEG_DT  = 24'd524;
	localparam logic [GAIN_W-1:0]  RST_GAIN_DERIV_DT  = 24'd819200;
	localparam logic [COUNT_W-1:0] RST_SPAN_COUNTS    = 10'd270;
	localparam logic [COUNT_W-1:0] RST_CLIP_MARGIN    = 10'd320;
	localparam logic [SP_W-1:0]    RST_START_SETPOINT = 7'd20;

	localparam logic [VAL_W-1:0] DUTY_LO    = 15'd1280;
	localparam logic [VAL_W-1:0] DUTY_HI    = 15'd24320;
	localparam logic [VAL_W-1:0] HEIGHT_MAX = 15'd32767;
	localparam logic [VAL_W-1:0] PCT_SCALE  = 15'd25600;

	localparam logic [SP_W-1:0] SP_MAX    = 7'd90;
	localparam logic [SP_W-1:0] SP_UP_MAX = 7'd80;
	localparam logic [SP_W-1:0] SP_STEP   = 7'd10;

	localparam logic [DIV_CNT_W-1:0] DIV_LAST = 4'(QBITS - 1);

	localparam logic signed [SUM_W-1:0] SUM_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [SUM_W-1:0] SUM_MIN = 32'sh8000_0000;

	localparam logic signed [ACC_W-1:0] CTL_LO = ACC_W'({DUTY_LO, 16'h0000});
	localparam logic signed [ACC_W-1:0] CTL_HI = ACC_W'({DUTY_HI, 16'h0000});

	typedef enum logic [1:0] {
		MUL_P = 2'd0,
		MUL_I = 2'd1,
		MUL_D = 2'd2
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_HOLD = 2'd0,
		ACC_LOAD = 2'd1,
		ACC_ADD  = 2'd2
	} acc_op_t;

	typedef struct packed {
		logic     accept;
		logic     mul_div;
		logic     div_init;
		logic     div_step;
		logic     div_last;
		logic     pid_err;
		logic     mul_en;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		logic     duty_load;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic long_path;
		logic div_skip;
	} stat_t;

endpackage

// ===== rtl/apc_ctrl.sv =====
`timescale 1ns / 1ps

module apc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	input  apc_pkg::stat_t stat,
	output apc_pkg::cmd_t  cmd
);

	typedef enum logic [10:0] {
		ST_IDLE    = 11'b000_0000_0001,
		ST_MUL     = 11'b000_0000_0010,
		ST_DIVINIT = 11'b000_0000_0100,
		ST_DIV     = 11'b000_0000_1000,
		ST_ERR     = 11'b000_0001_0000,
		ST_MP      = 11'b000_0010_0000,
		ST_MI      = 11'b000_0100_0000,
		ST_MD      = 11'b000_1000_0000,
		ST_ACC     = 11'b001_0000_0000,
		ST_CLAMP   = 11'b010_0000_0000,
		ST_DONE    = 11'b100_0000_0000
	} state_t;

	state_t                          state_q, state_nx;
	logic [apc_pkg::DIV_CNT_W-1:0]   cnt_q;
	logic                            m_tvalid_q;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

	always_comb begin
		state_nx = state_q;
		cmd = '0;
		cmd.mul_sel = apc_pkg::MUL_P;
		cmd.acc_op = apc_pkg::ACC_HOLD;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_nx = stat.long_path ? ST_MUL : ST_DONE;
				end
			end
			ST_MUL: begin
				cmd.mul_div = 1'b1;
				state_nx = ST_DIVINIT;
			end
			ST_DIVINIT: begin
				cmd.div_init = 1'b1;
				state_nx = stat.div_skip ? ST_ERR : ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == apc_pkg::DIV_LAST) begin
					cmd.div_last = 1'b1;
					state_nx = ST_ERR;
				end
			end
			ST_ERR: begin
				cmd.pid_err = 1'b1;
				state_nx = ST_MP;
			end
			ST_MP: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = apc_pkg::MUL_P;
				state_nx = ST_MI;
			end
			ST_MI: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = apc_pkg::MUL_I;
				cmd.acc_op = apc_pkg::ACC_LOAD;
				state_nx = ST_MD;
			end
			ST_MD: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = apc_pkg::MUL_D;
				cmd.acc_op = apc_pkg::ACC_ADD;
				state_nx = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc_op = apc_pkg::ACC_ADD;
				state_nx = ST_CLAMP;
			end
			ST_CLAMP: begin
				cmd.duty_load = 1'b1;
				state_nx = ST_DONE;
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_nx = ST_IDLE;
				end
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.div_init)
				cnt_q <= '0;
			else if (cmd.div_step)
				cnt_q <= cnt_q + 1'b1;
			if (cmd.out_load)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/apc_datapath.sv =====
`timescale 1ns / 1ps

module apc_datapath #(
	parameter int ADC_BITS = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [apc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [apc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  apc_pkg::opcode_t                    opcode,
	input  logic [ADC_BITS-1:0]                 adc_sample,
	input  apc_pkg::cmd_t                       cmd,
	output apc_pkg::stat_t                      stat,
	output logic [apc_pkg::VAL_W-1:0]           duty_q8,
	output logic                                rotor_on,
	output logic [apc_pkg::SP_W-1:0]            setpoint_pct,
	output logic [apc_pkg::VAL_W-1:0]           height_q8
);

	localparam int CW     = ((ADC_BITS > apc_pkg::COUNT_W) ? ADC_BITS : apc_pkg::COUNT_W) + 1;
	localparam int DIVD_W = ADC_BITS + apc_pkg::QBITS;

	// configuration
	logic [apc_pkg::GAIN_W-1:0]  gain_prop_q, gain_integ_q, gain_deriv_q;
	logic [apc_pkg::COUNT_W-1:0] span_q, margin_q;
	logic [apc_pkg::SP_W-1:0]    start_sp_q;

	// controller state
	logic [ADC_BITS-1:0]                ground_q, top_q;
	logic                               have_ground_q, flying_q;
	logic [apc_pkg::SP_W-1:0]           sp_q;
	logic signed [apc_pkg::SUM_W-1:0]   error_sum_q;
	logic signed [apc_pkg::ERR_W-1:0]   last_error_q, err_q;
	logic signed [apc_pkg::ERR_W:0]     derr_q;
	logic [apc_pkg::VAL_W-1:0]          duty_q, height_q;

	// divider
	logic [ADC_BITS-1:0]        num_q, den_q;
	logic [DIVD_W-1:0]          dividend_q, rem_q, dsr_q;
	logic [apc_pkg::QBITS-1:0]  quo_q;

	// multiply-accumulate
	logic signed [apc_pkg::ACC_W-1:0] prod_q, acc_q;

	// outputs
	logic [apc_pkg::VAL_W-1:0] out_duty_q, out_height_q;
	logic                      out_rotor_q;
	logic [apc_pkg::SP_W-1:0]  out_sp_q;

	logic [CW-1:0]             s_ext, span_ext, margin_ext, ground_ext;
	logic [ADC_BITS-1:0]       ground_new, sample_clip;
	logic                      clip;
	logic [apc_pkg::SP_W-1:0]  load_sp;
	logic                      div_sat, div_ge;
	logic signed [apc_pkg::ERR_W-1:0]   err_w;
	logic signed [apc_pkg::SUM_W:0]     sum_w;
	logic signed [apc_pkg::SUM_W-1:0]   sum_sat;
	logic signed [apc_pkg::MUL_A_W-1:0] mul_a;
	logic signed [apc_pkg::MUL_B_W-1:0] mul_b;

	assign s_ext      = CW'(adc_sample);
	assign span_ext   = CW'(span_q);
	assign margin_ext = CW'(margin_q);
	assign ground_ext = CW'(ground_q);
	assign ground_new = (adc_sample > ground_q) ? adc_sample : ground_q;
	assign clip       = (s_ext + margin_ext) < ground_ext;
	assign sample_clip = clip ? top_q : adc_sample;
	assign load_sp    = (start_sp_q > apc_pkg::SP_MAX) ? apc_pkg::SP_MAX : start_sp_q;

	assign stat.long_path = (opcode == apc_pkg::OP_SAMPLE) && have_ground_q;
	assign div_sat  = dividend_q >= {den_q, {apc_pkg::QBITS{1'b0}}};
	assign stat.div_skip = (den_q == '0) || div_sat;
	assign div_ge   = rem_q >= dsr_q;

	assign err_w   = $signed({1'b0, sp_q, 8'h00}) - $signed({1'b0, height_q});
	assign sum_w   = {error_sum_q[apc_pkg::SUM_W-1], error_sum_q}
		+ {{(apc_pkg::SUM_W + 1 - apc_pkg::ERR_W){err_w[apc_pkg::ERR_W-1]}}, err_w};
	assign sum_sat = (sum_w[apc_pkg::SUM_W] != sum_w[apc_pkg::SUM_W-1])
		? (sum_w[apc_pkg::SUM_W] ? apc_pkg::SUM_MIN : apc_pkg::SUM_MAX)
		: sum_w[apc_pkg::SUM_W-1:0];

	always_comb begin
		case (cmd.mul_sel)
			apc_pkg::MUL_I: begin
				mul_a = apc_pkg::MUL_A_W'(error_sum_q);
				mul_b = $signed({1'b0, gain_integ_q});
			end
			apc_pkg::MUL_D: begin
				mul_a = apc_pkg::MUL_A_W'(derr_q);
				mul_b = $signed({1'b0, gain_deriv_q});
			end
			default: begin
				mul_a = apc_pkg::MUL_A_W'(err_q);
				mul_b = $signed({1'b0, gain_prop_q});
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_prop_q  <= apc_pkg::RST_GAIN_PROP;
			gain_integ_q <= apc_pkg::RST_GAIN_INTEG_DT;
			gain_deriv_q <= apc_pkg::RST_GAIN_DERIV_DT;
			span_q       <= apc_pkg::RST_SPAN_COUNTS;
			margin_q     <= apc_pkg::RST_CLIP_MARGIN;
			start_sp_q   <= apc_pkg::RST_START_SETPOINT;
		end else if (cfg_wen) begin
			unique case (cfg_index)
				apc_pkg::REG_GAIN_PROP:      gain_prop_q  <= cfg_wdata;
				apc_pkg::REG_GAIN_INTEG_DT:  gain_integ_q <= cfg_wdata;
				apc_pkg::REG_GAIN_DERIV_DT:  gain_deriv_q <= cfg_wdata;
				apc_pkg::REG_SPAN_COUNTS:    span_q       <= cfg_wdata[apc_pkg::COUNT_W-1:0];
				apc_pkg::REG_CLIP_MARGIN:    margin_q     <= cfg_wdata[apc_pkg::COUNT_W-1:0];
				apc_pkg::REG_START_SETPOINT: start_sp_q   <= cfg_wdata[apc_pkg::SP_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ground_q      <= '0;
			top_q         <= '0;
			have_ground_q <= 1'b0;
			flying_q      <= 1'b0;
			sp_q          <= apc_pkg::RST_START_SETPOINT;
			error_sum_q   <= '0;
			last_error_q  <= '0;
			duty_q        <= apc_pkg::DUTY_LO;
			height_q      <= '0;
		end else begin
			if (cmd.accept) begin
				unique case (opcode)
					apc_pkg::OP_SAMPLE: begin
						if (!have_ground_q) begin
							ground_q <= adc_sample;
							top_q <= (s_ext >= span_ext) ? ADC_BITS'(s_ext - span_ext) : '0;
							have_ground_q <= 1'b1;
						end else begin
							ground_q <= ground_new;
						end
					end
					apc_pkg::OP_UP: begin
						if (sp_q <= apc_pkg::SP_UP_MAX)
							sp_q <= sp_q + apc_pkg::SP_STEP;
					end
					apc_pkg::OP_DOWN: begin
						if (sp_q >= apc_pkg::SP_STEP)
							sp_q <= sp_q - apc_pkg::SP_STEP;
					end
					apc_pkg::OP_TOGGLE: begin
						if (!flying_q) begin
							error_sum_q <= '0;
							last_error_q <= '0;
							sp_q <= load_sp;
							flying_q <= 1'b1;
						end else begin
							flying_q <= 1'b0;
						end
					end
					default: ;
				endcase
			end
			if (cmd.div_init) begin
				if (den_q == '0)
					height_q <= (num_q == '0) ? '0 : apc_pkg::HEIGHT_MAX;
				else if (div_sat)
					height_q <= apc_pkg::HEIGHT_MAX;
			end
			if (cmd.div_last)
				height_q <= {quo_q[apc_pkg::QBITS-2:0], div_ge};
			if (cmd.pid_err) begin
				error_sum_q <= sum_sat;
				last_error_q <= err_w;
			end
			if (cmd.duty_load) begin
				if (acc_q <= apc_pkg::CTL_LO)
					duty_q <= apc_pkg::DUTY_LO;
				else if (acc_q >= apc_pkg::CTL_HI)
					duty_q <= apc_pkg::DUTY_HI;
				else
					duty_q <= acc_q[apc_pkg::VAL_W+15:16];
			end
		end
	end

	// working registers, no reset needed
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			num_q <= ground_new - sample_clip;
			den_q <= ground_new - top_q;
		end
		if (cmd.mul_div)
			dividend_q <= DIVD_W'(num_q) * DIVD_W'(apc_pkg::PCT_SCALE);
		if (cmd.div_init) begin
			rem_q <= dividend_q;
			dsr_q <= DIVD_W'({den_q, {(apc_pkg::QBITS-1){1'b0}}});
			quo_q <= '0;
		end else if (cmd.div_step) begin
			if (div_ge)
				rem_q <= rem_q - dsr_q;
			dsr_q <= dsr_q >> 1;
			quo_q <= {quo_q[apc_pkg::QBITS-2:0], div_ge};
		end
		if (cmd.pid_err) begin
			err_q <= err_w;
			derr_q <= {err_w[apc_pkg::ERR_W-1], err_w}
				- {last_error_q[apc_pkg::ERR_W-1], last_error_q};
		end
		if (cmd.mul_en)
			prod_q <= mul_a * mul_b;
		case (cmd.acc_op)
			apc_pkg::ACC_LOAD: acc_q <= prod_q;
			apc_pkg::ACC_ADD:  acc_q <= acc_q + prod_q;
			default: ;
		endcase
		if (cmd.out_load) begin
			out_duty_q   <= duty_q;
			out_rotor_q  <= flying_q;
			out_sp_q     <= sp_q;
			out_height_q <= height_q;
		end
	end

	assign duty_q8      = out_duty_q;
	assign rotor_on     = out_rotor_q;
	assign setpoint_pct = out_sp_q;
	assign height_q8    = out_height_q;

endmodule

// ===== rtl/altitude_pid_controller_top.sv =====
`timescale 1ns / 1ps

// Height controller for a rotor craft, one item in, one result item out. Items are taken
// one at a time: s_tready is high only while the block is idle, and each result waits in
// an output register so the next item can be accepted before it is taken. Up, down,
// start/stop and the first (calibration) sample go straight to the output register, which raises
// m_tvalid once any earlier result has been taken. For a later height sample the height percent
// comes from a 15-step restoring divider (skipped when the quotient saturates or the span is
// zero), then the PID terms go one after another through a single shared 33x25 multiplier and
// a 58-bit accumulator before the duty is clamped to 5..95 percent. Configuration writes are
// taken on any cycle and must only be issued while the block is idle.
module altitude_pid_controller_top #(
	parameter int ADC_BITS = 10
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wen,
	input  logic [apc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [apc_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// opcode, adc_sample, zero pad
	input  logic [((ADC_BITS + 2 + 7) / 8) * 8 - 1:0] s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// duty_q8, rotor_on, setpoint_pct, height_q8, zero pad
	output logic [apc_pkg::OUT_TDATA_W-1:0]     m_tdata
);

	apc_pkg::cmd_t             cmd;
	apc_pkg::stat_t            stat;
	logic [apc_pkg::VAL_W-1:0] duty_q8, height_q8;
	logic                      rotor_on;
	logic [apc_pkg::SP_W-1:0]  setpoint_pct;

	apc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	apc_datapath #(
		.ADC_BITS (ADC_BITS)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_wen      (cfg_wen),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata),
		.opcode       (apc_pkg::opcode_t'(s_tdata[1:0])),
		.adc_sample   (s_tdata[ADC_BITS+1:2]),
		.cmd          (cmd),
		.stat         (stat),
		.duty_q8      (duty_q8),
		.rotor_on     (rotor_on),
		.setpoint_pct (setpoint_pct),
		.height_q8    (height_q8)
	);

	assign m_tdata = apc_pkg::OUT_TDATA_W'({height_q8, setpoint_pct, rotor_on, duty_q8});

endmodule

// ===== rtl/apc_checker.sv =====
`timescale 1ns / 1ps

module apc_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [apc_pkg::OUT_TDATA_W-1:0] m_tdata
);

	// a held result must not change
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one item at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second item accepted while busy");

	// duty stays inside the clamp
	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[14:0] >= apc_pkg::DUTY_LO) && (m_tdata[14:0] <= apc_pkg::DUTY_HI))
		else $error("duty out of clamp range");

	// setpoint never above its top
	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[22:16] <= apc_pkg::SP_MAX)
		else $error("setpoint out of range");

endmodule

bind altitude_pid_controller_top apc_checker u_apc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== bench/tb_altitude_pid_controller_top.sv =====
`timescale 1ns / 1ps

module tb_altitude_pid_controller_top;

	localparam int ADC_W = 10;
	localparam int IN_W = ((ADC_W + 2 + 7) / 8) * 8;
	localparam int N_ROWS = 26;
	localparam int N_PHASES = 7;
	localparam int PHASE_ITEMS = 275;
	localparam int LONG_HOLD = 300;
	localparam logic [apc_pkg::CFG_IDX_W-1:0] REG_PAST_END_LO = 3'd6;
	localparam logic [apc_pkg::CFG_IDX_W-1:0] REG_PAST_END_HI = 3'd7;

	typedef struct packed {
		logic [apc_pkg::VAL_W-1:0] duty;
		logic                      rotor;
		logic [apc_pkg::SP_W-1:0]  setpt;
		logic [apc_pkg::VAL_W-1:0] height;
	} readout_t;

	typedef struct {
		apc_pkg::opcode_t op;
		logic [ADC_W-1:0] adc;
		bit               typed;
		readout_t         want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wen = 1'b0;
	logic [apc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [apc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [apc_pkg::OUT_TDATA_W-1:0] m_tdata;

	// register copy
	logic [apc_pkg::GAIN_W-1:0] k_prop, k_integ, k_deriv;
	logic [apc_pkg::COUNT_W-1:0] span_cnt, margin_cnt;
	logic [apc_pkg::SP_W-1:0] sp_start;

	// controller state
	int unsigned ground_lv, top_lv;
	bit calibrated, flying;
	logic [apc_pkg::SP_W-1:0] setpt;
	int err_sum, prev_err;
	logic [apc_pkg::VAL_W-1:0] duty, height;

	readout_t readout_q[$];
	int bad_count = 0;
	int burst_left = 0;
	int hold_ticket = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int rx_cycle = 0;
	int rx_mode = 0;

	dir_row_t dir_tab [N_ROWS];
	logic [apc_pkg::CFG_DATA_W-1:0] phase_cfg [N_PHASES][6];

	altitude_pid_controller_top #(.ADC_BITS(ADC_W)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	always #4 clk = ~clk;

	initial begin
		#8_000_000;
		$display("[altitude_pid_controller_top] ERROR");
		$finish;
	end

	function automatic void model_reset();
		k_prop = apc_pkg::RST_GAIN_PROP;
		k_integ = apc_pkg::RST_GAIN_INTEG_DT;
		k_deriv = apc_pkg::RST_GAIN_DERIV_DT;
		span_cnt = apc_pkg::RST_SPAN_COUNTS;
		margin_cnt = apc_pkg::RST_CLIP_MARGIN;
		sp_start = apc_pkg::RST_START_SETPOINT;
		ground_lv = 0;
		top_lv = 0;
		calibrated = 1'b0;
		flying = 1'b0;
		setpt = apc_pkg::RST_START_SETPOINT;
		err_sum = 0;
		prev_err = 0;
		duty = apc_pkg::DUTY_LO;
		height = '0;
	endfunction

	function automatic void model_write(logic [apc_pkg::CFG_IDX_W-1:0] idx,
			logic [apc_pkg::CFG_DATA_W-1:0] val);
		case (idx)
			apc_pkg::REG_GAIN_PROP: k_prop = val[apc_pkg::GAIN_W-1:0];
			apc_pkg::REG_GAIN_INTEG_DT: k_integ = val[apc_pkg::GAIN_W-1:0];
			apc_pkg::REG_GAIN_DERIV_DT: k_deriv = val[apc_pkg::GAIN_W-1:0];
			apc_pkg::REG_SPAN_COUNTS: span_cnt = val[apc_pkg::COUNT_W-1:0];
			apc_pkg::REG_CLIP_MARGIN: margin_cnt = val[apc_pkg::COUNT_W-1:0];
			apc_pkg::REG_START_SETPOINT: sp_start = val[apc_pkg::SP_W-1:0];
			default: ;
		endcase
	endfunction

	function automatic logic [apc_pkg::SP_W-1:0] loaded_setpt();
		return (sp_start > apc_pkg::SP_MAX) ? apc_pkg::SP_MAX : sp_start;
	endfunction

	function automatic logic [apc_pkg::VAL_W-1:0] height_pct(int unsigned s);
		int unsigned num, den;
		longint unsigned h;
		num = ground_lv - s;
		den = ground_lv - top_lv;
		if (den == 0)
			return (num == 0) ? '0 : apc_pkg::HEIGHT_MAX;
		h = (longint'(num) * longint'(apc_pkg::PCT_SCALE)) / longint'(den);
		return (h > apc_pkg::HEIGHT_MAX) ? apc_pkg::HEIGHT_MAX : apc_pkg::VAL_W'(h);
	endfunction

	function automatic void ctl_update();
		int err;
		longint sum, ctl, lo, hi;
		err = int'({setpt, 8'h00}) - int'(height);
		sum = longint'(err_sum) + longint'(err);
		if (sum > longint'(apc_pkg::SUM_MAX)) sum = longint'(apc_pkg::SUM_MAX);
		if (sum < longint'(apc_pkg::SUM_MIN)) sum = longint'(apc_pkg::SUM_MIN);
		err_sum = int'(sum);
		ctl = longint'(err) * longint'(k_prop)
			+ longint'(err_sum) * longint'(k_integ)
			+ (longint'(err) - longint'(prev_err)) * longint'(k_deriv);
		prev_err = err;
		lo = longint'(apc_pkg::DUTY_LO) * 65536;
		hi = longint'(apc_pkg::DUTY_HI) * 65536;
		if (ctl <= lo)
			duty = apc_pkg::DUTY_LO;
		else if (ctl >= hi)
			duty = apc_pkg::DUTY_HI;
		else
			duty = apc_pkg::VAL_W'(ctl >>> 16);
	endfunction

	function automatic readout_t next_readout(apc_pkg::opcode_t op, logic [ADC_W-1:0] adc);
		int unsigned s;
		readout_t r;
		s = adc;
		case (op)
			apc_pkg::OP_SAMPLE: begin
				if (!calibrated) begin
					ground_lv = s;
					top_lv = (s >= span_cnt) ? s - span_cnt : 0;
					calibrated = 1'b1;
				end else begin
					if (s > ground_lv)
						ground_lv = s;
					if (s + margin_cnt < ground_lv)
						s = top_lv;
					height = height_pct(s);
					ctl_update();
				end
			end
			apc_pkg::OP_UP: begin
				if (setpt <= apc_pkg::SP_UP_MAX)
					setpt = setpt + apc_pkg::SP_STEP;
			end
			apc_pkg::OP_DOWN: begin
				if (setpt >= apc_pkg::SP_STEP)
					setpt = setpt - apc_pkg::SP_STEP;
			end
			default: begin
				if (!flying) begin
					err_sum = 0;
					prev_err = 0;
					setpt = loaded_setpt();
					flying = 1'b1;
				end else begin
					flying = 1'b0;
				end
			end
		endcase
		r.duty = duty;
		r.rotor = flying;
		r.setpt = setpt;
		r.height = height;
		return r;
	endfunction

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		bad_count++;
	endtask

	task automatic check_result(input logic [apc_pkg::OUT_TDATA_W-1:0] d);
		readout_t want;
		if (readout_q.size() == 0) begin
			flag_mismatch("unexpected item", longint'(d), 0);
			return;
		end
		want = readout_q.pop_front();
		if (d[14:0] !== want.duty) flag_mismatch("duty_q8", d[14:0], want.duty);
		if (d[15] !== want.rotor) flag_mismatch("rotor_on", d[15], want.rotor);
		if (d[22:16] !== want.setpt) flag_mismatch("setpoint_pct", d[22:16], want.setpt);
		if (d[37:23] !== want.height) flag_mismatch("height_q8", d[37:23], want.height);
	endtask

	// result side: random ready modes plus an occasional long hold-off
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_result(m_tdata);
		rx_cycle <= rx_cycle + 1;
		if (hold_ticket != hold_seen) begin
			hold_seen <= hold_ticket;
			hold_left <= LONG_HOLD;
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			m_tready <= 1'b0;
		end else begin
			if (rx_cycle % 64 == 0)
				rx_mode <= $urandom_range(0, 3);
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= ((rx_cycle % 8) != 0);
			endcase
		end
	end

	task automatic write_reg(input logic [apc_pkg::CFG_IDX_W-1:0] idx,
			input logic [apc_pkg::CFG_DATA_W-1:0] val);
		cfg_wen <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		model_write(idx, val);
	endtask

	task automatic send_item(input apc_pkg::opcode_t op, input logic [ADC_W-1:0] adc,
			input bit typed, input readout_t want);
		readout_t r;
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_W - ADC_W - 2){1'b0}}, adc, op};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		r = next_readout(op, adc);
		readout_q.push_back(typed ? want : r);
	endtask

	task automatic pace();
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6);
		end
	endtask

	task automatic drain();
		s_tvalid <= 1'b0;
		while (readout_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic random_item();
		apc_pkg::opcode_t op;
		logic [ADC_W-1:0] adc;
		int pick;
		pick = $urandom_range(0, 99);
		adc = ADC_W'($urandom);
		if (pick < 65) begin
			op = apc_pkg::OP_SAMPLE;
			case ($urandom_range(0, 7))
				0: adc = '0;
				1: adc = '1;
				2, 3: adc = ADC_W'($urandom);
				default: adc = ADC_W'($urandom_range(600, 1023));
			endcase
		end else if (pick < 80) begin
			op = apc_pkg::OP_UP;
		end else if (pick < 93) begin
			op = apc_pkg::OP_DOWN;
		end else begin
			op = apc_pkg::OP_TOGGLE;
		end
		send_item(op, adc, 1'b0, '0);
	endtask

	initial begin
		dir_tab = '{
			'{apc_pkg::OP_UP, 10'd0, 1'b1, '{apc_pkg::DUTY_LO, 1'b0, 7'd30, 15'd0}},
			'{apc_pkg::OP_DOWN, 10'd1023, 1'b1, '{apc_pkg::DUTY_LO, 1'b0, 7'd20, 15'd0}},
			'{apc_pkg::OP_TOGGLE, 10'd0, 1'b1,
				'{apc_pkg::DUTY_LO, 1'b1, apc_pkg::SP_MAX, 15'd0}},
			'{apc_pkg::OP_UP, 10'd0, 1'b1,
				'{apc_pkg::DUTY_LO, 1'b1, apc_pkg::SP_MAX, 15'd0}},
			'{apc_pkg::OP_SAMPLE, 10'd100, 1'b1,
				'{apc_pkg::DUTY_LO, 1'b1, apc_pkg::SP_MAX, 15'd0}},
			'{apc_pkg::OP_SAMPLE, 10'd100, 1'b0, '0},
			'{apc_pkg::OP_SAMPLE, 10'd0, 1'b0, '0},
			'{apc_pkg::OP_TOGGLE, 10'd0, 1'b0, '0},
			'{apc_pkg::OP_TOGGLE, 10'd0, 1'b0, '0},
			'{apc_pkg::OP_DOWN, 10'd0, 1'b0, '0},
			'{apc_pkg::OP_DOWN, 10'd0, 1'b0, '0},
			'{apc_pkg::OP_DOWN, 10'd0, 1'b0, '0},
			'{apc_pkg::OP_DOWN, 10'd0, 1'b0, '0},
			'{apc_pkg::OP_DOWN, 10'd0, 1'b0, '0},
			'{apc_pkg::OP_DOWN, 10'd0, 1'b0, '0},
			'{apc_pkg::OP_DOWN, 10'd0, 1'b0, '0},
			'{apc_pkg::OP_DOWN, 10'd0, 1'b0, '0},
			'{apc_pkg::OP_DOWN, 10'd0, 1'b0, '0},
			'{apc_pkg::OP_DOWN, 10'd0, 1'b0, '0},
			'{apc_pkg::OP_SAMPLE, 10'd1023, 1'b0, '0},
			'{apc_pkg::OP_SAMPLE, 10'd0, 1'b0, '0},
			'{apc_pkg::OP_SAMPLE, 10'd703, 1'b0, '0},
			'{apc_pkg::OP_SAMPLE, 10'd702, 1'b0, '0},
			'{apc_pkg::OP_UP, 10'd0, 1'b0, '0},
			'{apc_pkg::OP_TOGGLE, 10'd0, 1'b0, '0},
			'{apc_pkg::OP_SAMPLE, 10'd900, 1'b0, '0}
		};
		phase_cfg[0] = '{24'd0, 24'd0, 24'd0, 24'd5, 24'h000400, 24'd0};
		phase_cfg[1] = '{24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h0003FF, 24'h0003FF, 24'd90};
		phase_cfg[2] = '{apc_pkg::RST_GAIN_PROP, apc_pkg::RST_GAIN_INTEG_DT,
			apc_pkg::RST_GAIN_DERIV_DT, 24'(apc_pkg::RST_SPAN_COUNTS),
			24'(apc_pkg::RST_CLIP_MARGIN), 24'(apc_pkg::RST_START_SETPOINT)};
		phase_cfg[3] = '{24'h0A0000, 24'd2000, 24'd300000, 24'd1, 24'd1, 24'd45};
		for (int p = 4; p < N_PHASES; p++)
			phase_cfg[p] = '{24'($urandom), 24'($urandom), 24'($urandom),
				24'($urandom), 24'($urandom), 24'($urandom_range(0, 127))};
		model_reset();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero span through masking, setpoint load above the limit, writes past the list
		write_reg(apc_pkg::REG_SPAN_COUNTS, 24'hFFFC00);
		write_reg(apc_pkg::REG_START_SETPOINT, 24'hFFFFFF);
		write_reg(REG_PAST_END_LO, 24'h123456);
		write_reg(REG_PAST_END_HI, 24'hFFFFFF);
		cfg_wen <= 1'b0;

		foreach (dir_tab[i]) begin
			send_item(dir_tab[i].op, dir_tab[i].adc, dir_tab[i].typed, dir_tab[i].want);
			pace();
		end

		for (int p = 0; p < N_PHASES; p++) begin
			drain();
			write_reg(apc_pkg::REG_GAIN_PROP, phase_cfg[p][apc_pkg::REG_GAIN_PROP]);
			write_reg(apc_pkg::REG_GAIN_INTEG_DT, phase_cfg[p][apc_pkg::REG_GAIN_INTEG_DT]);
			write_reg(apc_pkg::REG_GAIN_DERIV_DT, phase_cfg[p][apc_pkg::REG_GAIN_DERIV_DT]);
			write_reg(apc_pkg::REG_SPAN_COUNTS, phase_cfg[p][apc_pkg::REG_SPAN_COUNTS]);
			write_reg(apc_pkg::REG_CLIP_MARGIN, phase_cfg[p][apc_pkg::REG_CLIP_MARGIN]);
			write_reg(apc_pkg::REG_START_SETPOINT,
				phase_cfg[p][apc_pkg::REG_START_SETPOINT]);
			cfg_wen <= 1'b0;
			if (p == 1)
				hold_ticket <= hold_ticket + 1;
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 2 && n == PHASE_ITEMS / 2)
					drain();
				random_item();
				pace();
			end
		end

		drain();
		repeat (40) @(posedge clk);
		if (bad_count == 0)
			$display("[altitude_pid_controller_top] OK");
		else
			$display("[altitude_pid_controller_top] ERROR");
		$finish;
	end

endmodule
